// ===== rtl/iss_pkg.sv =====
// ----------------------------------------------------------------------------
// Influence seed selector package
// Shared widths, codes and the command/status structs between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int unsigned MAX_NODES_DEF = 1024;
  localparam int unsigned MAX_EDGES_DEF = 8192;
  localparam int unsigned MAX_SEEDS_DEF = 64;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SRC_W    = 10;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned SCORE_W  = 48;
  localparam int unsigned RANK_W   = 6;
  localparam int unsigned NODE_OUT_W = 10;
  localparam int unsigned ITER_W   = 5;
  localparam int unsigned SEEDCFG_W = 7;
  localparam int unsigned NODECFG_W = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned EDGE_W = 2 * SRC_W + WEIGHT_W;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT = 2'd0,
    CFG_ITER_COUNT = 2'd1,
    CFG_SEED_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RUN_START,
    OP_CLR_WR,
    OP_EDGE_RD,
    OP_EDGE_LAT,
    OP_EDGE_MUL,
    OP_EDGE_WR,
    OP_BCPY_RD,
    OP_BCPY_WR,
    OP_PCPY_RD,
    OP_PCPY_WR,
    OP_MAX_RD,
    OP_MAX_CMP,
    OP_EMIT,
    OP_MARK,
    OP_SEED_NEXT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   walk_base;
    logic   iter_next;
  } dp_cmd_t;

  typedef struct packed {
    logic v_last;
    logic e_end;
    logic it_end;
    logic r_last;
    logic out_busy;
    logic seeds_zero;
  } dp_stat_t;

endpackage

// ===== rtl/influence_seed_selector.sv =====
// ----------------------------------------------------------------------------
// Influence seed selector
// Greedy seed selection over a weighted directed graph held in an edge store.
// ----------------------------------------------------------------------------
// Edges are loaded one per transfer on the input stream (kind 0); a clear
// transfer (kind 2) empties the store. A run transfer (kind 1) computes each
// node's base score from its outgoing edge weights, propagates scores over the
// configured rounds and then emits seed_count seeds (at most MAX_SEEDS), one
// output transfer per seed, in selection order. The input is not ready again
// until the run has finished. A run is bound by the single edge walk engine
// and by sweeps over the node score memories. Weights are unsigned Q1.16 and
// scores unsigned Q32.16, with every sum saturating at the top of the 48-bit
// range. Edges loaded while the store is full are dropped and flag
// edges_dropped on later results.
// ----------------------------------------------------------------------------
module influence_seed_selector #(
  parameter int unsigned MAX_NODES = iss_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES = iss_pkg::MAX_EDGES_DEF,
  parameter int unsigned MAX_SEEDS = iss_pkg::MAX_SEEDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // edge_source [9:0], edge_target [19:10], edge_weight [36:20], zero pad
  input  logic [iss_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // kind [1:0]
  input  logic [iss_pkg::KIND_W-1:0]      s_axis_tuser,
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // seed_node [9:0], seed_rank [15:10]
  output logic [iss_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast,
  // edges_dropped [0]
  output logic                            m_axis_tuser,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [iss_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [iss_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import iss_pkg::*;

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic                 idle;
  logic                 in_accept;
  logic [NODE_OUT_W-1:0] seed_node;
  logic [RANK_W-1:0]    seed_rank;

  // The block takes a transfer only when no run is in flight.
  assign s_axis_tready = idle;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  iss_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_accept_i (in_accept),
    .in_kind_i   (s_axis_tuser),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .idle_o      (idle)
  );

  iss_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES),
    .MAX_SEEDS (MAX_SEEDS)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_accept_i   (in_accept),
    .in_kind_i     (s_axis_tuser),
    .in_src_i      (s_axis_tdata[SRC_W-1:0]),
    .in_tgt_i      (s_axis_tdata[2*SRC_W-1:SRC_W]),
    .in_weight_i   (s_axis_tdata[EDGE_W-1:2*SRC_W]),
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_node_o    (seed_node),
    .out_rank_o    (seed_rank),
    .out_last_o    (m_axis_tlast),
    .out_dropped_o (m_axis_tuser)
  );

  assign m_axis_tdata = {seed_rank, seed_node};

endmodule

// ===== rtl/iss_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/iss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Influence seed selector controller
// Sequences the sweeps and edge walks of one run and issues datapath commands.
// ----------------------------------------------------------------------------
module iss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_accept_i,
  input  logic [1:0]        in_kind_i,
  input  iss_pkg::dp_stat_t stat_i,
  output iss_pkg::dp_cmd_t  cmd_o,
  output logic              idle_o
);

  import iss_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_E_RD, S_E_LAT, S_E_MUL, S_E_WR, S_SC_RD, S_SC_WR,
    S_SNEXT, S_ICHK, S_PC_RD, S_PC_WR, S_ITER, S_M_RD, S_M_CMP, S_EMIT,
    S_MARK
  } state_e;

  state_e state_q, state_d;
  logic   walk_base_q, walk_base_d;
  logic   seed_copy_q, seed_copy_d;

  always_comb begin
    state_d       = state_q;
    walk_base_d   = walk_base_q;
    seed_copy_d   = seed_copy_q;
    cmd_o.op        = OP_NONE;
    cmd_o.walk_base = walk_base_q;
    cmd_o.iter_next = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_accept_i && (in_kind_i == KIND_RUN) && !stat_i.seeds_zero) begin
          cmd_o.op = OP_RUN_START;
          state_d  = S_CLR;
        end
      end
      S_CLR: begin
        cmd_o.op = OP_CLR_WR;
        if (stat_i.v_last) begin
          walk_base_d = 1'b1;
          state_d     = S_E_RD;
        end
      end
      S_E_RD: begin
        cmd_o.op = OP_EDGE_RD;
        if (stat_i.e_end) begin
          if (walk_base_q) begin
            seed_copy_d = 1'b0;
            state_d     = S_SC_RD;
          end else begin
            state_d = S_ITER;
          end
        end else begin
          state_d = S_E_LAT;
        end
      end
      S_E_LAT: begin
        cmd_o.op = OP_EDGE_LAT;
        state_d  = S_E_MUL;
      end
      S_E_MUL: begin
        cmd_o.op = OP_EDGE_MUL;
        state_d  = S_E_WR;
      end
      S_E_WR: begin
        cmd_o.op = OP_EDGE_WR;
        state_d  = S_E_RD;
      end
      S_SC_RD: begin
        cmd_o.op = OP_BCPY_RD;
        state_d  = S_SC_WR;
      end
      S_SC_WR: begin
        cmd_o.op = OP_BCPY_WR;
        if (stat_i.v_last) begin
          state_d = seed_copy_q ? S_SNEXT : S_ICHK;
        end else begin
          state_d = S_SC_RD;
        end
      end
      S_SNEXT: begin
        cmd_o.op = OP_SEED_NEXT;
        state_d  = stat_i.r_last ? S_IDLE : S_ICHK;
      end
      S_ICHK: begin
        state_d = stat_i.it_end ? S_M_RD : S_PC_RD;
      end
      S_PC_RD: begin
        cmd_o.op = OP_PCPY_RD;
        state_d  = S_PC_WR;
      end
      S_PC_WR: begin
        cmd_o.op = OP_PCPY_WR;
        if (stat_i.v_last) begin
          walk_base_d = 1'b0;
          state_d     = S_E_RD;
        end else begin
          state_d = S_PC_RD;
        end
      end
      S_ITER: begin
        cmd_o.iter_next = 1'b1;
        state_d         = S_ICHK;
      end
      S_M_RD: begin
        cmd_o.op = OP_MAX_RD;
        state_d  = S_M_CMP;
      end
      S_M_CMP: begin
        cmd_o.op = OP_MAX_CMP;
        state_d  = stat_i.v_last ? S_EMIT : S_M_RD;
      end
      S_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_MARK;
        end
      end
      S_MARK: begin
        cmd_o.op    = OP_MARK;
        seed_copy_d = 1'b1;
        state_d     = S_SC_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      walk_base_q <= 1'b0;
      seed_copy_q <= 1'b0;
      idle_o      <= 1'b1;
    end else begin
      state_q     <= state_d;
      walk_base_q <= walk_base_d;
      seed_copy_q <= seed_copy_d;
      idle_o      <= (state_d == S_IDLE);
    end
  end

endmodule

// ===== rtl/iss_datapath.sv =====
// ----------------------------------------------------------------------------
// Influence seed selector datapath
// Edge store, score memories, counters, multiply-accumulate and result register.
// ----------------------------------------------------------------------------
module iss_datapath #(
  parameter int unsigned MAX_NODES = iss_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES = iss_pkg::MAX_EDGES_DEF,
  parameter int unsigned MAX_SEEDS = iss_pkg::MAX_SEEDS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  iss_pkg::dp_cmd_t                    cmd_i,
  output iss_pkg::dp_stat_t                   stat_o,
  input  logic                                in_accept_i,
  input  logic [iss_pkg::KIND_W-1:0]          in_kind_i,
  input  logic [iss_pkg::SRC_W-1:0]           in_src_i,
  input  logic [iss_pkg::SRC_W-1:0]           in_tgt_i,
  input  logic [iss_pkg::WEIGHT_W-1:0]        in_weight_i,
  input  logic                                cfg_we_i,
  input  logic [iss_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [iss_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [iss_pkg::NODE_OUT_W-1:0]      out_node_o,
  output logic [iss_pkg::RANK_W-1:0]          out_rank_o,
  output logic                                out_last_o,
  output logic                                out_dropped_o
);

  import iss_pkg::*;

  localparam int unsigned NodeW = $clog2(MAX_NODES);
  localparam int unsigned NcW   = NodeW + 1;
  localparam int unsigned EaW   = $clog2(MAX_EDGES);
  localparam int unsigned EcW   = $clog2(MAX_EDGES + 1);
  localparam int unsigned SkW   = $clog2(MAX_SEEDS + 1);
  localparam int unsigned CmpW  = ((NodeW > SRC_W) ? NodeW : SRC_W) + 1;
  localparam int unsigned ItW   = ITER_W + 1;

  // Configuration registers
  logic [NODECFG_W-1:0] node_cfg_q;
  logic [ITER_W-1:0]    iter_cfg_q;
  logic [SEEDCFG_W-1:0] seed_cfg_q;

  // Run control
  logic [NcW-1:0]   n_q;
  logic [SkW-1:0]   k_q, r_q;
  logic [ITER_W-1:0] iter_q;
  logic [ItW-1:0]   it_q;
  logic [NodeW-1:0] v_q;
  logic [EcW-1:0]   e_q, edge_total_q;
  logic             overflow_q;

  // Edge and product registers
  logic [NodeW-1:0]     s_q;
  logic                 valid_q;
  logic [WEIGHT_W-1:0]  w_q;
  logic [SCORE_W-1:0]   upd_q;
  logic                 chosen_q;
  logic [48:0]          phi_q;
  logic [32:0]          plo_q;
  logic [NodeW-1:0]     best_q;
  logic [SCORE_W-1:0]   best_score_q;

  // Memories
  logic                 edge_we;
  logic [EaW-1:0]       edge_waddr, edge_raddr;
  logic [EDGE_W-1:0]    edge_wdata, edge_rdata;
  logic                 base_we, a_we, b_we, ch_we;
  logic [NodeW-1:0]     base_waddr, base_raddr, a_waddr, a_raddr, b_waddr, b_raddr;
  logic [NodeW-1:0]     ch_waddr, ch_raddr;
  logic [SCORE_W-1:0]   base_wdata, base_rdata, a_wdata, a_rdata, b_wdata, b_rdata;
  logic                 ch_wdata, ch_rdata;

  logic [SRC_W-1:0]     rd_src, rd_tgt;
  logic [WEIGHT_W-1:0]  rd_w;
  logic                 rd_valid;
  logic                 upd_is_b;
  logic [SCORE_W-1:0]   look_rd, upd_rd, rank_rd;
  logic [49:0]          sum;
  logic [SCORE_W-1:0]   sum_sat;
  logic                 edge_wr_en;
  logic                 store_full;
  logic [NcW-1:0]       v_next;

  assign store_full = (edge_total_q == EcW'(MAX_EDGES));
  assign rd_src     = edge_rdata[SRC_W-1:0];
  assign rd_tgt     = edge_rdata[2*SRC_W-1:SRC_W];
  assign rd_w       = edge_rdata[EDGE_W-1:2*SRC_W];
  assign rd_valid   = (CmpW'(rd_src) < CmpW'(n_q)) && (CmpW'(rd_tgt) < CmpW'(n_q));
  // Even rounds update the even array from the odd one.
  assign upd_is_b   = ~it_q[0];
  assign look_rd    = upd_is_b ? a_rdata : b_rdata;
  assign upd_rd     = upd_is_b ? b_rdata : a_rdata;

  always_comb begin
    if (iter_q <= ITER_W'(1)) begin
      rank_rd = base_rdata;
    end else if (!iter_q[0]) begin
      rank_rd = b_rdata;
    end else begin
      rank_rd = a_rdata;
    end
  end

  always_comb begin
    if (cmd_i.walk_base) begin
      sum = 50'(upd_q) + 50'(w_q);
    end else begin
      sum = 50'(upd_q) + 50'(phi_q) + 50'(plo_q[32:16]);
    end
    sum_sat    = (|sum[49:48]) ? SCORE_MAX : sum[SCORE_W-1:0];
    edge_wr_en = (cmd_i.op == OP_EDGE_WR) && valid_q && (cmd_i.walk_base || !chosen_q);
    v_next     = {1'b0, v_q} + NcW'(1);
  end

  // Memory port steering
  always_comb begin
    edge_we    = in_accept_i && (in_kind_i == KIND_LOAD) && !store_full;
    edge_waddr = edge_total_q[EaW-1:0];
    edge_wdata = {in_weight_i, in_tgt_i, in_src_i};
    edge_raddr = e_q[EaW-1:0];

    base_we = 1'b0; base_waddr = v_q; base_wdata = '0; base_raddr = v_q;
    a_we    = 1'b0; a_waddr    = v_q; a_wdata    = '0; a_raddr    = v_q;
    b_we    = 1'b0; b_waddr    = v_q; b_wdata    = '0; b_raddr    = v_q;
    ch_we   = 1'b0; ch_waddr   = v_q; ch_wdata   = 1'b0;
    ch_raddr = NodeW'(rd_src);

    case (cmd_i.op)
      OP_CLR_WR: begin
        base_we = 1'b1;
        ch_we   = 1'b1;
      end
      OP_EDGE_LAT: begin
        base_raddr = NodeW'(rd_src);
        a_raddr    = upd_is_b ? NodeW'(rd_tgt) : NodeW'(rd_src);
        b_raddr    = upd_is_b ? NodeW'(rd_src) : NodeW'(rd_tgt);
      end
      OP_EDGE_WR: begin
        if (cmd_i.walk_base) begin
          base_we    = edge_wr_en;
          base_waddr = s_q;
          base_wdata = sum_sat;
        end else if (upd_is_b) begin
          b_we    = edge_wr_en;
          b_waddr = s_q;
          b_wdata = sum_sat;
        end else begin
          a_we    = edge_wr_en;
          a_waddr = s_q;
          a_wdata = sum_sat;
        end
      end
      OP_BCPY_WR: begin
        a_we    = 1'b1;
        a_wdata = base_rdata;
        b_we    = 1'b1;
      end
      OP_PCPY_WR: begin
        if (upd_is_b) begin
          b_we    = 1'b1;
          b_wdata = look_rd;
        end else begin
          a_we    = 1'b1;
          a_wdata = look_rd;
        end
      end
      OP_MARK: begin
        base_we    = 1'b1;
        base_waddr = best_q;
        ch_we      = 1'b1;
        ch_waddr   = best_q;
        ch_wdata   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  iss_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );
  iss_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_NODES)) u_base_ram (
    .clk_i, .we_i(base_we), .waddr_i(base_waddr), .wdata_i(base_wdata),
    .raddr_i(base_raddr), .rdata_o(base_rdata)
  );
  iss_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_NODES)) u_odd_ram (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(a_wdata),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );
  iss_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_NODES)) u_even_ram (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .raddr_i(b_raddr), .rdata_o(b_rdata)
  );
  iss_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_chosen_ram (
    .clk_i, .we_i(ch_we), .waddr_i(ch_waddr), .wdata_i(ch_wdata),
    .raddr_i(ch_raddr), .rdata_o(ch_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_cfg_q   <= NODECFG_W'(1024);
      iter_cfg_q   <= ITER_W'(3);
      seed_cfg_q   <= SEEDCFG_W'(8);
      n_q          <= '0;
      k_q          <= '0;
      r_q          <= '0;
      iter_q       <= '0;
      it_q         <= '0;
      v_q          <= '0;
      e_q          <= '0;
      edge_total_q <= '0;
      overflow_q   <= 1'b0;
      out_valid_o  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_NODE_COUNT: node_cfg_q <= cfg_data_i[NODECFG_W-1:0];
          CFG_ITER_COUNT: iter_cfg_q <= cfg_data_i[ITER_W-1:0];
          CFG_SEED_COUNT: seed_cfg_q <= cfg_data_i[SEEDCFG_W-1:0];
          default: begin
          end
        endcase
      end

      if (in_accept_i && (in_kind_i == KIND_LOAD)) begin
        if (store_full) begin
          overflow_q <= 1'b1;
        end else begin
          edge_total_q <= edge_total_q + EcW'(1);
        end
      end else if (in_accept_i && (in_kind_i == KIND_CLEAR)) begin
        edge_total_q <= '0;
        overflow_q   <= 1'b0;
      end

      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end

      if (cmd_i.iter_next) begin
        it_q <= it_q + ItW'(1);
      end

      case (cmd_i.op)
        OP_RUN_START: begin
          if (node_cfg_q == '0) begin
            n_q <= NcW'(1);
          end else if (32'(node_cfg_q) > 32'(MAX_NODES)) begin
            n_q <= NcW'(MAX_NODES);
          end else begin
            n_q <= NcW'(node_cfg_q);
          end
          k_q    <= (32'(seed_cfg_q) > 32'(MAX_SEEDS)) ? SkW'(MAX_SEEDS) : SkW'(seed_cfg_q);
          iter_q <= iter_cfg_q;
          r_q    <= '0;
          it_q   <= ItW'(2);
          v_q    <= '0;
          e_q    <= '0;
        end
        OP_CLR_WR, OP_BCPY_WR, OP_PCPY_WR, OP_MAX_CMP: begin
          v_q <= (v_next == n_q) ? '0 : v_next[NodeW-1:0];
        end
        OP_EDGE_RD: begin
          if (e_q == edge_total_q) begin
            e_q <= '0;
          end
        end
        OP_EDGE_WR: begin
          e_q <= e_q + EcW'(1);
        end
        OP_EMIT: begin
          out_valid_o <= 1'b1;
        end
        OP_SEED_NEXT: begin
          r_q  <= r_q + SkW'(1);
          it_q <= ItW'(2);
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_EDGE_LAT: begin
        s_q     <= NodeW'(rd_src);
        valid_q <= rd_valid;
        w_q     <= rd_w;
      end
      OP_EDGE_MUL: begin
        upd_q    <= cmd_i.walk_base ? base_rdata : upd_rd;
        chosen_q <= ch_rdata;
        phi_q    <= 49'(w_q) * 49'(look_rd[SCORE_W-1:16]);
        plo_q    <= 33'(w_q) * 33'(look_rd[15:0]);
      end
      OP_MAX_CMP: begin
        if ((v_q == '0) || (rank_rd > best_score_q)) begin
          best_q       <= v_q;
          best_score_q <= rank_rd;
        end
      end
      OP_EMIT: begin
        out_node_o    <= NODE_OUT_W'(best_q);
        out_rank_o    <= RANK_W'(r_q);
        out_last_o    <= (r_q + SkW'(1) == k_q);
        out_dropped_o <= overflow_q;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.v_last     = (v_next == n_q);
  assign stat_o.e_end      = (e_q == edge_total_q);
  assign stat_o.it_end     = (it_q > ItW'(iter_q));
  assign stat_o.r_last     = (r_q + SkW'(1) == k_q);
  assign stat_o.out_busy   = out_valid_o;
  assign stat_o.seeds_zero = (seed_cfg_q == '0);

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EMIT) |-> !out_valid_o)
    else $error("result overwritten before transfer");
  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_total_q <= EcW'(MAX_EDGES))
    else $error("edge count beyond store capacity");
  a_best_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EMIT) |-> ({1'b0, best_q} < n_q))
    else $error("seed outside active node range");
  a_edge_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EDGE_LAT) |=> (cmd_i.op == OP_EDGE_MUL))
    else $error("edge walk sequence broken");
`endif

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Influence seed selector testbench
// Loads small weighted graphs, starts seed runs under several register
// settings and checks every emitted seed against a score model kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import iss_pkg::*;

  localparam int unsigned NODE_LIM = 1024;
  localparam int unsigned EDGE_LIM = 8192;
  localparam int unsigned SEED_LIM = 64;
  localparam int unsigned IDLE_LIMIT = 300000;
  localparam int unsigned SETTLE = 40;
  localparam int unsigned HOLD_LEN = 400;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef logic [SCORE_W-1:0] score_t;

  // One seed as it should leave the block.
  typedef struct {
    logic [9:0] node;
    logic [5:0] rank;
    logic       last;
    logic       dropped;
  } seed_t;

  // A row of the directed plan: either a stream transfer or a register write.
  typedef struct {
    bit         is_cfg;
    logic [1:0] kind;
    int         a;
    int         b;
    int         c;
    bit         known;
    logic [9:0] node;
  } row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic [KIND_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  influence_seed_selector dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Model state: edge store, flags, registers and score arrays.
  logic [9:0]  edge_src [EDGE_LIM];
  logic [9:0]  edge_dst [EDGE_LIM];
  logic [16:0] edge_wt  [EDGE_LIM];
  int          edge_cnt;
  bit          store_overflow;
  int          cfg_nodes;
  int          cfg_rounds;
  int          cfg_seeds;
  score_t      score_base [NODE_LIM];
  score_t      score_odd  [NODE_LIM];
  score_t      score_even [NODE_LIM];
  bit          picked     [NODE_LIM];

  seed_t seeds_pending [$];
  int    errors;
  int    runs_started;
  int    seeds_checked;
  int    edges_sent;
  int    burst_left;
  bit    hold_req;
  int    idle_cycles;
  int    rx_cycle;

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic score_t sum_sat(input score_t x, input logic [63:0] y);
    logic [63:0] s;
    s = {16'd0, x} + y;
    return (s > {16'd0, SCORE_MAX}) ? SCORE_MAX : s[SCORE_W-1:0];
  endfunction

  // Q1.16 weight times Q32.16 score, floored, split to keep it exact.
  function automatic logic [63:0] apply_weight(input logic [16:0] w, input score_t s);
    logic [63:0] p;
    p = 64'(w) * 64'(s >> 16) + ((64'(w) * 64'(s[15:0])) >> 16);
    return (p > {16'd0, SCORE_MAX}) ? {16'd0, SCORE_MAX} : p;
  endfunction

  // One propagation round; to_even picks which array is refreshed from the other.
  task automatic spread_round(input bit to_even, input int n);
    score_t look;
    for (int v = 0; v < n; v++) begin
      if (!picked[v]) begin
        if (to_even) score_even[v] = score_odd[v];
        else score_odd[v] = score_even[v];
      end
    end
    for (int e = 0; e < edge_cnt; e++) begin
      if (edge_src[e] >= n || edge_dst[e] >= n || picked[edge_src[e]] || picked[edge_dst[e]])
        continue;
      if (to_even) begin
        look = score_odd[edge_dst[e]];
        score_even[edge_src[e]] = sum_sat(score_even[edge_src[e]],
                                          apply_weight(edge_wt[e], look));
      end else begin
        look = score_even[edge_dst[e]];
        score_odd[edge_src[e]] = sum_sat(score_odd[edge_src[e]],
                                         apply_weight(edge_wt[e], look));
      end
    end
  endtask

  // Greedy selection for one run transfer; queues one seed per pick.
  task automatic predict_seeds();
    int n;
    int k;
    int best;
    score_t top;
    score_t cand;
    seed_t sd;
    n = (cfg_nodes < 1) ? 1 : ((cfg_nodes > NODE_LIM) ? NODE_LIM : cfg_nodes);
    k = (cfg_seeds > SEED_LIM) ? SEED_LIM : cfg_seeds;
    for (int v = 0; v < NODE_LIM; v++) picked[v] = 1'b0;
    for (int v = 0; v < n; v++) score_base[v] = '0;
    for (int e = 0; e < edge_cnt; e++) begin
      if (edge_src[e] < n && edge_dst[e] < n)
        score_base[edge_src[e]] = sum_sat(score_base[edge_src[e]], 64'(edge_wt[e]));
    end
    for (int v = 0; v < n; v++) begin
      score_odd[v] = score_base[v];
      score_even[v] = '0;
    end
    for (int r = 0; r < k; r++) begin
      for (int it = 2; it <= cfg_rounds; it++) spread_round(it % 2 == 0, n);
      best = 0;
      for (int v = 0; v < n; v++) begin
        if (cfg_rounds <= 1) cand = score_base[v];
        else if (cfg_rounds % 2 == 0) cand = score_even[v];
        else cand = score_odd[v];
        if (v == 0 || cand > top) begin
          top = cand;
          best = v;
        end
      end
      sd.node = best[9:0];
      sd.rank = r[5:0];
      sd.last = (r + 1 == k);
      sd.dropped = store_overflow;
      seeds_pending.push_back(sd);
      picked[best] = 1'b1;
      score_base[best] = '0;
      for (int v = 0; v < n; v++) begin
        score_odd[v] = picked[v] ? '0 : score_base[v];
        score_even[v] = '0;
      end
    end
  endtask

  // Updates the model for one accepted input transfer.
  task automatic absorb(input logic [1:0] kind, input int src, input int dst, input int wt);
    case (kind)
      KIND_LOAD: begin
        if (edge_cnt < EDGE_LIM) begin
          edge_src[edge_cnt] = src[9:0];
          edge_dst[edge_cnt] = dst[9:0];
          edge_wt[edge_cnt] = wt[16:0];
          edge_cnt++;
        end else begin
          store_overflow = 1'b1;
        end
        edges_sent++;
      end
      KIND_CLEAR: begin
        edge_cnt = 0;
        store_overflow = 1'b0;
      end
      KIND_RUN: begin
        runs_started++;
        predict_seeds();
      end
      default: ;
    endcase
  endtask

  // Offers one transfer in bursts with random gaps and waits for acceptance.
  task automatic send(input logic [1:0] kind, input int src, input int dst, input int wt);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {3'b000, wt[16:0], dst[9:0], src[9:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    absorb(kind, src, dst, wt);
  endtask

  // Pauses the sender until every seed has come and the block is idle again.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (seeds_pending.size() != 0 || !s_axis_tready) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One register write; the enable drops again before the next write.
  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_NODE_COUNT: cfg_nodes = value & 'h7FF;
      CFG_ITER_COUNT: cfg_rounds = value & 'h1F;
      CFG_SEED_COUNT: cfg_seeds = value & 'h7F;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_regs(input int nodes, input int rounds, input int seeds);
    wait_idle();
    write_reg(CFG_NODE_COUNT, nodes);
    write_reg(CFG_ITER_COUNT, rounds);
    write_reg(CFG_SEED_COUNT, seeds);
  endtask

  // Result side: compares each accepted seed with the oldest one waiting.
  always @(posedge clk_i) begin
    seed_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (seeds_pending.size() == 0) begin
        $display("[%0t] seed %0d arrived with none outstanding", $time, m_axis_tdata[9:0]);
        errors++;
      end else begin
        want = seeds_pending.pop_front();
        seeds_checked++;
        if (m_axis_tdata[9:0] !== want.node) report("seed_node", m_axis_tdata[9:0], want.node);
        if (m_axis_tdata[15:10] !== want.rank)
          report("seed_rank", m_axis_tdata[15:10], want.rank);
        if (m_axis_tlast !== want.last) report("last_seed", m_axis_tlast, want.last);
        if (m_axis_tuser !== want.dropped) report("edges_dropped", m_axis_tuser, want.dropped);
      end
    end
  end

  // Receiver: cycles through always-ready, light and heavy random stalls and a
  // fixed pattern; on request it holds off for a long stretch on its own.
  always begin
    @(posedge clk_i);
    rx_cycle++;
    if (hold_req) begin
      m_axis_tready <= 1'b0;
      repeat (HOLD_LEN) @(posedge clk_i);
      hold_req = 1'b0;
    end else begin
      case ((rx_cycle >> 7) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ($urandom_range(0, 9) < 3);
        default: m_axis_tready <= (rx_cycle % 3 == 0);
      endcase
    end
  end

  // Watchdog on cycles in which neither side moves a transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without a transfer", idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Random load-then-run sequences for one register setting.
  task automatic random_phase(input int items, input bit with_hold);
    int n;
    int sent;
    int group;
    int src;
    int dst;
    n = (cfg_nodes < 1) ? 1 : ((cfg_nodes > NODE_LIM) ? NODE_LIM : cfg_nodes);
    sent = 0;
    while (sent < items) begin
      group = $urandom_range(2, 9);
      for (int i = 0; i < group; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send(($urandom_range(0, 1) != 0) ? KIND_SPARE : KIND_CLEAR,
               $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 65536));
        end else begin
          src = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, n - 1);
          dst = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, n - 1);
          send(KIND_LOAD, src, dst,
               ($urandom_range(0, 7) == 0) ? 65536 : $urandom_range(0, 65535));
        end
        sent++;
      end
      // The hold-off starts with a run so the block fills and stops taking input.
      if (with_hold && !hold_req) hold_req = 1'b1;
      send(KIND_RUN, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 65536));
      sent++;
    end
  endtask

  row_t plan [$];
  row_t row;
  int   mark;

  initial begin
    errors = 0;
    edge_cnt = 0;
    store_overflow = 1'b0;
    cfg_nodes = 1024;
    cfg_rounds = 3;
    cfg_seeds = 8;
    burst_left = 0;
    hold_req = 1'b0;
    idle_cycles = 0;
    rx_cycle = 0;
    runs_started = 0;
    seeds_checked = 0;
    edges_sent = 0;

    // Directed plan. Known rows carry the seed node that every pick must give.
    // An empty graph at reset settings: every score is zero, node 0 repeats.
    plan.push_back('{0, KIND_RUN, 0, 0, 0, 1, 10'd0});
    plan.push_back('{0, KIND_SPARE, 1023, 1023, 65536, 0, 10'd0});
    plan.push_back('{1, 2'd0, CFG_NODE_COUNT, 8, 0, 0, 10'd0});
    plan.push_back('{1, 2'd0, CFG_SEED_COUNT, 4, 0, 0, 10'd0});
    plan.push_back('{0, KIND_LOAD, 7, 0, 65536, 0, 10'd0});
    plan.push_back('{0, KIND_LOAD, 0, 7, 65535, 0, 10'd0});
    plan.push_back('{0, KIND_LOAD, 3, 3, 40000, 0, 10'd0});
    plan.push_back('{0, KIND_LOAD, 1023, 2, 65536, 0, 10'd0});
    plan.push_back('{0, KIND_LOAD, 2, 1023, 65536, 0, 10'd0});
    plan.push_back('{0, KIND_LOAD, 5, 6, 0, 0, 10'd0});
    plan.push_back('{0, KIND_LOAD, 0, 1, 1, 0, 10'd0});
    plan.push_back('{0, KIND_RUN, 0, 0, 0, 0, 10'd0});
    // From here the nodes are ranked by their base scores alone.
    plan.push_back('{1, 2'd0, CFG_ITER_COUNT, 1, 0, 0, 10'd0});
    plan.push_back('{0, KIND_LOAD, 4, 5, 0, 0, 10'd0});
    plan.push_back('{0, KIND_CLEAR, 0, 0, 0, 0, 10'd0});
    plan.push_back('{0, KIND_LOAD, 6, 1, 65536, 0, 10'd0});
    plan.push_back('{0, KIND_RUN, 0, 0, 0, 0, 10'd0});
    plan.push_back('{0, KIND_CLEAR, 1023, 1023, 65536, 0, 10'd0});
    plan.push_back('{0, KIND_RUN, 0, 0, 0, 1, 10'd0});
    // Node count zero behaves as one node.
    plan.push_back('{1, 2'd0, CFG_NODE_COUNT, 0, 0, 0, 10'd0});
    plan.push_back('{1, 2'd0, CFG_ITER_COUNT, 0, 0, 0, 10'd0});
    plan.push_back('{0, KIND_LOAD, 0, 0, 65536, 0, 10'd0});
    plan.push_back('{0, KIND_RUN, 0, 0, 0, 1, 10'd0});
    // No seeds requested: the run produces nothing.
    plan.push_back('{1, 2'd0, CFG_SEED_COUNT, 0, 0, 0, 10'd0});
    plan.push_back('{0, KIND_RUN, 0, 0, 0, 0, 10'd0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        wait_idle();
        write_reg(cfg_idx_e'(row.a), row.b);
      end else begin
        mark = seeds_pending.size();
        send(row.kind, row.a, row.b, row.c);
        if (row.known)
          for (int j = mark; j < seeds_pending.size(); j++) seeds_pending[j].node = row.node;
      end
    end

    // Random part over several settings, extremes included.
    set_regs(16, 1, 5);
    random_phase(25, 1'b0);
    set_regs(12, 2, 6);
    random_phase(30, 1'b1);
    set_regs(20, 16, 3);
    random_phase(20, 1'b0);
    set_regs(2047, 4, 2);
    random_phase(20, 1'b0);
    set_regs(8, 31, 127);
    random_phase(25, 1'b0);
    set_regs(32, 5, 64);
    random_phase(20, 1'b0);
    set_regs(6, 2, 1);
    random_phase(25, 1'b0);

    // A small graph after a clear, the same graph with one more edge, then a clear and a single edge.
    set_regs(4, 1, 2);
    send(KIND_CLEAR, 0, 0, 0);
    for (int i = 0; i < 6; i++)
      send(KIND_LOAD, $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 65536));
    send(KIND_RUN, 0, 0, 0);
    send(KIND_LOAD, 1, 2, 65536);
    send(KIND_RUN, 0, 0, 0);
    send(KIND_CLEAR, 0, 0, 0);
    send(KIND_LOAD, 2, 3, 100);
    send(KIND_RUN, 0, 0, 0);

    wait_idle();

    $display("Covered %0d runs and %0d seeds over %0d edge loads,", runs_started,
             seeds_checked, edges_sent);
    $display("including an empty graph, stray edges, clears and register extremes.");
    if (errors == 0 && seeds_pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d seeds never arrived", errors, seeds_pending.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/iss_pkg.sv
rtl/iss_ram.sv
rtl/iss_ctrl.sv
rtl/iss_datapath.sv
rtl/influence_seed_selector.sv
test/tb.sv
